// File: hdl/text_display_changed_char_refresh_core_defines.svh
// Assertion macros for the text display refresh core checker.
`ifndef TEXT_DISPLAY_CHANGED_CHAR_REFRESH_CORE_DEFINES_SVH
`define TEXT_DISPLAY_CHANGED_CHAR_REFRESH_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TDCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tdcr assertion failed");

// Next-cycle implication, disabled in reset.
`define TDCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tdcr assertion failed");

`endif

// File: hdl/tdcr_pkg.sv
// Shared types and constants of the text display refresh core.
package tdcr_pkg;

    localparam logic [7:0] SPACE_CODE = 8'h20;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_DRAW = 2'd2;

    localparam logic [1:0] KIND_ADDR   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TWO   = 2'd2;

    localparam logic [7:0] ADDR_BASE_RESET = 8'd128;
    localparam logic [6:0] ROW_ONE_RESET   = 7'd0;
    localparam logic [6:0] ROW_TWO_RESET   = 7'd64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] mode;
        logic       line_select;
        logic [3:0] column;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
        logic       ready_to_draw;
    } t_out_item;

    typedef struct packed {
        logic [7:0] addr_base;
        logic [6:0] row_one;
        logic [6:0] row_two;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_STATUS = 2'd1,
        OP_DRAW   = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       line_select;
        logic [3:0] column;
        logic [7:0] ch;
        logic       ready;
    } t_cmd;

endpackage

// File: hdl/tdcr_front.sv
// Front end: accepts items, tracks fill and change flags, issues commands.
module tdcr_front
    import tdcr_pkg::*;
#(
    parameter int LINE_CHARS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic r_fill, r_changed, r_ready;
    logic n_fill, n_changed, n_ready;
    logic accept, in_range, fill_now;

    always_comb begin
        accept    = i_in_valid && !i_q_full;
        in_range  = {4'd0, i_in_item.column} < 8'(LINE_CHARS);
        fill_now  = ((i_in_item.column != 4'd0) && r_fill) || (i_in_item.char_code == 8'd0);
        n_fill    = r_fill;
        n_changed = r_changed;
        n_ready   = r_ready;
        o_push    = 1'b0;
        o_cmd.op          = OP_WRITE;
        o_cmd.line_select = i_in_item.line_select;
        o_cmd.column      = i_in_item.column;
        o_cmd.ch          = fill_now ? SPACE_CODE : i_in_item.char_code;
        o_cmd.ready       = r_ready;
        if (accept) begin
            unique case (i_in_item.mode)
                MODE_LOAD: begin
                    if (in_range) begin
                        n_fill    = fill_now;
                        n_changed = 1'b1;
                        o_push    = 1'b1;
                    end
                end
                MODE_TICK: begin
                    n_ready     = r_ready || r_changed;
                    o_cmd.op    = OP_STATUS;
                    o_cmd.ready = n_ready;
                    o_push      = 1'b1;
                end
                MODE_DRAW: begin
                    n_changed = 1'b0;
                    n_ready   = 1'b0;
                    o_cmd.op  = OP_DRAW;
                    o_push    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 1'b0;
            r_changed <= 1'b0;
            r_ready   <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_changed <= n_changed;
            r_ready   <= n_ready;
        end
    end

endmodule

// File: hdl/tdcr_queue.sv
// Command queue between front end and back end.
module tdcr_queue
    import tdcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

// File: hdl/tdcr_back.sv
// Back end: text stores, status results and the changed-character walk.
module tdcr_back
    import tdcr_pkg::*;
#(
    parameter int LINE_CHARS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int DEPTH = 2 * LINE_CHARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_ADDR  = 6'b001000,
        ST_DATA  = 6'b010000,
        ST_FLUSH = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_col, n_col, r_prev, n_prev;
    logic            r_line, n_line, r_have_prev, n_have_prev;
    logic            r_out_v, n_out_v, r_hold_v, n_hold_v;
    t_out_item       r_out, n_out, r_hold, n_hold;

    logic [7:0]      r_pmem [DEPTH];
    logic [7:0]      r_smem [DEPTH];
    logic [DEPTH-1:0] r_pv, r_sv;
    logic [7:0]      r_prd, r_srd;
    logic            r_pvq, r_svq;

    logic            can_emit, emit, differ, need_addr, last_col, advance;
    logic            pwr_en, swr_en;
    logic [AW-1:0]   cmd_idx;
    logic [7:0]      cur_p, cur_s, addr_byte;
    logic [6:0]      offset;
    t_out_item       new_item;

    always_comb begin
        can_emit  = !r_out_v || !i_out_stall;
        cur_p     = r_pvq ? r_prd : SPACE_CODE;
        cur_s     = r_svq ? r_srd : SPACE_CODE;
        differ    = cur_p != cur_s;
        need_addr = !r_have_prev || ({1'b0, r_col} != ({1'b0, r_prev} + 1'b1));
        last_col  = r_col == CW'(LINE_CHARS - 1);
        offset    = r_line ? i_cfg.row_two : i_cfg.row_one;
        addr_byte = i_cfg.addr_base | (8'(offset) + 8'(r_col));
        cmd_idx   = AW'((i_cmd.line_select ? LINE_CHARS : 0) + int'(i_cmd.column));

        n_state     = r_state;
        n_addr      = r_addr;
        n_col       = r_col;
        n_line      = r_line;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_out_v     = r_out_v && i_out_stall;
        n_out       = r_out;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        o_cmd_pop   = 1'b0;
        pwr_en      = 1'b0;
        swr_en      = 1'b0;
        emit        = 1'b0;
        advance     = 1'b0;
        new_item.kind          = KIND_DATA;
        new_item.out_byte      = cur_p;
        new_item.last          = 1'b0;
        new_item.ready_to_draw = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_WRITE: begin
                            pwr_en    = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        OP_STATUS: begin
                            if (can_emit) begin
                                o_cmd_pop             = 1'b1;
                                n_out_v               = 1'b1;
                                n_out.kind            = KIND_STATUS;
                                n_out.out_byte        = 8'd0;
                                n_out.last            = 1'b1;
                                n_out.ready_to_draw   = i_cmd.ready;
                            end
                        end
                        OP_DRAW: begin
                            o_cmd_pop   = 1'b1;
                            n_addr      = '0;
                            n_col       = '0;
                            n_line      = 1'b0;
                            n_have_prev = 1'b0;
                            n_state     = ST_READ;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                swr_en = 1'b1;
                if (!differ) begin
                    advance = 1'b1;
                end else if (need_addr) begin
                    n_state = ST_ADDR;
                end else begin
                    n_state = ST_DATA;
                end
            end
            ST_ADDR: begin
                if (can_emit) begin
                    emit              = 1'b1;
                    new_item.kind     = KIND_ADDR;
                    new_item.out_byte = addr_byte;
                    n_state           = ST_DATA;
                end
            end
            ST_DATA: begin
                if (can_emit) begin
                    emit        = 1'b1;
                    n_prev      = r_col;
                    n_have_prev = 1'b1;
                    advance     = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (can_emit) begin
                    n_out_v    = 1'b1;
                    n_out      = r_hold;
                    n_out.last = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            if (r_hold_v) begin
                n_out_v = 1'b1;
                n_out   = r_hold;
            end
            n_hold_v = 1'b1;
            n_hold   = new_item;
        end

        if (advance) begin
            if (last_col && r_line) begin
                n_state = ST_FLUSH;
            end else begin
                n_state = ST_READ;
                n_addr  = r_addr + 1'b1;
                if (last_col) begin
                    n_col       = '0;
                    n_line      = 1'b1;
                    n_have_prev = 1'b0;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pwr_en) begin
            r_pmem[cmd_idx] <= i_cmd.ch;
        end
        if (swr_en) begin
            r_smem[r_addr] <= cur_p;
        end
        if (r_state == ST_READ) begin
            r_prd <= r_pmem[r_addr];
            r_srd <= r_smem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_col       <= '0;
            r_line      <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_out_v     <= 1'b0;
            r_hold_v    <= 1'b0;
            r_pv        <= '0;
            r_sv        <= '0;
            r_pvq       <= 1'b0;
            r_svq       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_line      <= n_line;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_out_v     <= n_out_v;
            r_hold_v    <= n_hold_v;
            if (pwr_en) begin
                r_pv[cmd_idx] <= 1'b1;
            end
            if (swr_en) begin
                r_sv[r_addr] <= 1'b1;
            end
            if (r_state == ST_READ) begin
                r_pvq <= r_pv[r_addr];
                r_svq <= r_sv[r_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

// File: hdl/text_display_changed_char_refresh_core.sv
// Load: one item per cycle while the queue is not full, no result. Tick: status result
// is queued, then registered at the output. Draw: the walk sequencer reads each text
// position through the registered store reads, then emits the bytes of changed ones.
// A four-entry command queue lets loads and ticks keep arriving during a walk.
// Reset is synchronous: flags and queue clear, both text copies read as spaces at once.
// Top level of the text display refresh core.
module text_display_changed_char_refresh_core
    import tdcr_pkg::*;
#(
    parameter int LINE_CHARS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata
);

    t_cfg r_cfg;
    logic push, q_full, q_valid, pop;
    t_cmd push_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.addr_base <= ADDR_BASE_RESET;
            r_cfg.row_one   <= ROW_ONE_RESET;
            r_cfg.row_two   <= ROW_TWO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDR_BASE: r_cfg.addr_base <= i_cfg_wdata;
                CFG_ROW_ONE:   r_cfg.row_one   <= i_cfg_wdata[6:0];
                CFG_ROW_TWO:   r_cfg.row_two   <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;

    tdcr_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_item (i_in_item),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    tdcr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_full (q_full),
        .o_cmd  (q_cmd)
    );

    tdcr_back #(
        .LINE_CHARS(LINE_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_cmd_pop  (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

// File: hdl/tdcr_checker.sv
// Port-level checker for the text display refresh core, with its bind.
`include "text_display_changed_char_refresh_core_defines.svh"

module tdcr_checker
    import tdcr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `TDCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `TDCR_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_out_valid && (o_out_item.kind == KIND_STATUS), o_out_item.last)
    `TDCR_ASSERT_NOW(a_draw_not_ready, i_clk, i_rst_n, o_out_valid && (o_out_item.kind == KIND_ADDR || o_out_item.kind == KIND_DATA), !o_out_item.ready_to_draw)
    `TDCR_ASSERT_NOW(a_addr_not_last, i_clk, i_rst_n, o_out_valid && (o_out_item.kind == KIND_ADDR), !o_out_item.last)

endmodule

bind text_display_changed_char_refresh_core tdcr_checker u_tdcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

// File: verif/testbench.sv
// Self-checking testbench for the two-line text display changed-character refresh core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tdcr_pkg::*;

    localparam int LINE_CHARS = 16;
    localparam int SETTLE_CYCLES = 160;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class refresh_scoreboard;
        logic [7:0] pending_chars [2*LINE_CHARS];
        logic [7:0] shown_chars [2*LINE_CHARS];
        bit text_changed;
        bit draw_ready;
        bit space_fill;
        t_cfg regs;
        t_out_item expected_results[$];
        int errors;

        function new();
            foreach (pending_chars[i]) begin
                pending_chars[i] = SPACE_CODE;
                shown_chars[i] = SPACE_CODE;
            end
            regs.addr_base = ADDR_BASE_RESET;
            regs.row_one = ROW_ONE_RESET;
            regs.row_two = ROW_TWO_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                CFG_ADDR_BASE: regs.addr_base = data;
                CFG_ROW_ONE: regs.row_one = data[6:0];
                CFG_ROW_TWO: regs.row_two = data[6:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] value);
            t_out_item r;
            r.kind = kind;
            r.out_byte = value;
            r.last = 1'b0;
            r.ready_to_draw = draw_ready;
            expected_results.push_back(r);
        endfunction

        function void walk_line(int line, logic [6:0] offset);
            int prev;
            int idx;
            prev = -2;
            for (int col = 0; col < LINE_CHARS; col++) begin
                idx = line * LINE_CHARS + col;
                if (pending_chars[idx] != shown_chars[idx]) begin
                    if (col != prev + 1)
                        push_result(KIND_ADDR, regs.addr_base | (8'(offset) + 8'(col)));
                    push_result(KIND_DATA, pending_chars[idx]);
                    prev = col;
                end
            end
        endfunction

        function void note_item(t_in_item it);
            int first;
            int idx;
            first = expected_results.size();
            idx = int'(it.line_select) * LINE_CHARS + int'(it.column);
            case (it.mode)
                MODE_LOAD: begin
                    if (it.column == 4'd0)
                        space_fill = 1'b0;
                    if (it.char_code == 8'h00)
                        space_fill = 1'b1;
                    pending_chars[idx] = space_fill ? SPACE_CODE : it.char_code;
                    text_changed = 1'b1;
                end
                MODE_TICK: begin
                    if (text_changed)
                        draw_ready = 1'b1;
                    push_result(KIND_STATUS, 8'h00);
                end
                MODE_DRAW: begin
                    text_changed = 1'b0;
                    draw_ready = 1'b0;
                    walk_line(0, regs.row_one);
                    walk_line(1, regs.row_two);
                    shown_chars = pending_chars;
                end
                default: ;
            endcase
            if (expected_results.size() > first)
                expected_results[$].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", 8'(want.kind), 8'(got.kind));
                compare_field("out_byte", want.out_byte, got.out_byte);
                compare_field("last", 8'(want.last), 8'(got.last));
                compare_field("ready_to_draw", 8'(want.ready_to_draw),
                              8'(got.ready_to_draw));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [7:0]           i_cfg_wdata = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    refresh_scoreboard sb = new();

    text_display_changed_char_refresh_core #(
        .LINE_CHARS(LINE_CHARS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_item);
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_in_item);
        end
    end

    task automatic send_item(logic [1:0] mode, logic ln, logic [3:0] col, logic [7:0] code);
        t_in_item it;
        it.mode = mode;
        it.line_select = ln;
        it.column = col;
        it.char_code = code;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_load(logic ln, logic [3:0] col, logic [7:0] code);
        send_item(MODE_LOAD, ln, col, code);
    endtask

    task automatic send_op(logic [1:0] mode);
        send_item(mode, 1'($urandom_range(1)), 4'($urandom_range(15)),
                  8'($urandom_range(255)));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_config(logic [7:0] base, logic [6:0] row_one, logic [6:0] row_two);
        write_reg(CFG_ADDR_BASE, base);
        write_reg(CFG_ROW_ONE, {1'b0, row_one});
        write_reg(CFG_ROW_TWO, {1'b0, row_two});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] string_char();
        if ($urandom_range(2) == 0)
            return 8'($urandom_range(1, 255));
        return 8'h61 + 8'($urandom_range(1));
    endfunction

    task automatic run_directed();
        send_op(MODE_TICK);
        send_op(MODE_DRAW);
        send_op(MODE_UNUSED);
        send_load(1'b0, 4'd0, 8'h41);
        send_load(1'b0, 4'd1, 8'hFF);
        send_load(1'b0, 4'd2, 8'h01);
        send_load(1'b0, 4'd3, 8'h80);
        send_load(1'b0, 4'd15, 8'h7E);
        send_load(1'b1, 4'd0, 8'h48);
        send_load(1'b1, 4'd1, 8'h00);
        send_load(1'b1, 4'd2, 8'h51);
        send_load(1'b1, 4'd15, 8'h5A);
        send_op(MODE_TICK);
        send_op(MODE_TICK);
        send_op(MODE_DRAW);
        drain();
        send_op(MODE_TICK);
        send_op(MODE_DRAW);
        // rewrite a shown character with itself
        send_load(1'b0, 4'd0, 8'h41);
        send_op(MODE_TICK);
        send_op(MODE_DRAW);
        send_load(1'b1, 4'd0, 8'h00);
        send_load(1'b0, 4'd0, 8'h7A);
        send_op(MODE_DRAW);
        send_op(MODE_TICK);
    endtask

    task automatic random_segment(int quota);
        int sent;
        int len;
        int stop;
        logic ln;
        sent = 0;
        while (sent < quota) begin
            case ($urandom_range(9))
                0: begin
                    send_load(1'($urandom_range(1)), 4'($urandom_range(15)),
                              8'($urandom_range(255)));
                    sent++;
                end
                1: begin
                    send_op(MODE_UNUSED);
                    sent++;
                end
                2: begin
                    send_op(MODE_TICK);
                    sent++;
                end
                3: begin
                    send_op(MODE_DRAW);
                    sent++;
                end
                default: begin
                    ln = 1'($urandom_range(1));
                    len = $urandom_range(1, LINE_CHARS);
                    stop = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : LINE_CHARS;
                    for (int col = 0; col < len; col++)
                        send_load(ln, 4'(col), (col == stop) ? 8'h00 : string_char());
                    sent += len;
                    if ($urandom_range(9) < 7) begin
                        send_op(MODE_TICK);
                        sent++;
                    end
                    if ($urandom_range(9) < 6) begin
                        send_op(MODE_DRAW);
                        sent++;
                    end
                    if ($urandom_range(7) == 0)
                        drain();
                end
            endcase
        end
    endtask

    initial begin
        #8ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 11;
        stall_pct = 76;
        run_directed();
        for (int seg = 0; seg < 6; seg++) begin
            if (seg > 0)
                settle();
            if (seg == 2) begin
                send_idle_pct = 76;
                stall_pct = 11;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            case (seg)
                1: write_config(8'd0, 7'd0, 7'd0);
                2: write_config(8'd255, 7'd127, 7'd127);
                3, 5: write_config(8'($urandom_range(255)), 7'($urandom_range(127)),
                                   7'($urandom_range(127)));
                4: write_config(8'd128, 7'd127, 7'd0);
                default: ;
            endcase
            random_segment(18);
        end
        settle();
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
